// ===== rtl/pcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types and constants for the prefix-code bit packer.
// ----------------------------------------------------------------------------
package pcbp_pkg;

  localparam int unsigned SymW    = 8;
  localparam int unsigned CodeW   = 32;
  localparam int unsigned LenW    = 6;
  localparam int unsigned NumSyms = 256;
  localparam int unsigned AccW    = CodeW + 7;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = 2;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  typedef enum logic [1:0] {
    KIND_ENC,
    KIND_MISS,
    KIND_FIN
  } kind_e;

  // work handed from the lookup stage to the packer
  typedef struct packed {
    kind_e             kind;
    logic [CodeW-1:0]  code;
    logic [LenW-1:0]   len;
  } qent_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] padding_bits;
    logic       stream_end;
    logic       missing_symbol;
    logic       last;
  } res_t;

endpackage

// ===== rtl/pcbp_front.sv =====
// ----------------------------------------------------------------------------
// pcbp_front
// Accepts items, maintains the code table, looks up symbols and classifies
// each encode/finish item for the packer queue.
// ----------------------------------------------------------------------------
module pcbp_front #(
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            action_i,
  input  logic [7:0]            symbol_i,
  input  logic [31:0]           code_value_i,
  input  logic [5:0]            code_length_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output pcbp_pkg::qent_t       push_ent_o
);
  import pcbp_pkg::*;

  localparam int unsigned LenCap = (MAX_CODE_LEN < CodeW) ? MAX_CODE_LEN : CodeW;

  logic [CodeW-1:0] code_mem [NumSyms];
  logic [LenW-1:0]  len_mem  [NumSyms];
  logic [NumSyms-1:0] vld_q;

  logic             s1_vld_q;
  logic             s1_fin_q;
  logic             rd_vld_q;
  logic [CodeW-1:0] rd_code_q;
  logic [LenW-1:0]  rd_len_q;

  logic             accept;
  logic             is_load;
  logic             is_work;
  logic [LenW-1:0]  len_sat;

  assign in_ready_o = !s1_vld_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_load    = (action_i == ACT_LOAD);
  assign is_work    = (action_i == ACT_ENCODE) || (action_i == ACT_FINISH);
  assign len_sat    = (code_length_i > LenW'(LenCap)) ? LenW'(LenCap) : code_length_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (accept && is_load) begin
      vld_q[symbol_i] <= 1'b1;
    end
  end

  // write and read share the accept edge; a later item sees the new entry
  always_ff @(posedge clk_i) begin
    if (accept && is_load) begin
      code_mem[symbol_i] <= code_value_i;
      len_mem[symbol_i]  <= len_sat;
    end
    if (accept) begin
      rd_code_q <= code_mem[symbol_i];
      rd_len_q  <= len_mem[symbol_i];
      rd_vld_q  <= vld_q[symbol_i];
      s1_fin_q  <= (action_i == ACT_FINISH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (accept) begin
      s1_vld_q <= is_work;
    end else if (push_ready_i) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_comb begin
    push_valid_o    = s1_vld_q;
    push_ent_o.code = rd_code_q;
    push_ent_o.len  = rd_len_q;
    if (s1_fin_q) begin
      push_ent_o.kind = KIND_FIN;
    end else if (rd_vld_q) begin
      push_ent_o.kind = KIND_ENC;
    end else begin
      push_ent_o.kind = KIND_MISS;
    end
  end

endmodule

// ===== rtl/pcbp_queue.sv =====
// ----------------------------------------------------------------------------
// pcbp_queue
// Short FIFO between the lookup stage and the packer.
// ----------------------------------------------------------------------------
module pcbp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  pcbp_pkg::qent_t push_ent_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output pcbp_pkg::qent_t pop_ent_o
);
  import pcbp_pkg::*;

  qent_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != (QPtrW+1)'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_ent_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/pcbp_back.sv =====
// ----------------------------------------------------------------------------
// pcbp_back
// Bit packer: appends codes to the stream residue and emits one word per
// cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module pcbp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  pcbp_pkg::qent_t q_ent_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pcbp_pkg::res_t  out_res_o
);
  import pcbp_pkg::*;

  // acc_q holds the stream bits not yet emitted, right aligned; tot_q counts them
  logic [AccW-1:0]  acc_q, acc_d;
  logic [LenW-1:0]  tot_q, tot_d;
  logic             ovld_q;
  res_t             ores_q;

  logic             can_out;
  logic             emit_ok;
  logic [LenW-1:0]  tot_cur;
  logic [LenW-1:0]  sh;
  logic [AccW-1:0]  shifted;
  logic [2:0]       cnt;
  logic [6:0]       pend;
  logic [CodeW-1:0] code_m;
  logic [AccW-1:0]  acc_new;
  logic             pop_enc, pop_side;
  logic [2:0]       pad;
  logic [7:0]       fin_byte;

  assign can_out  = !ovld_q || out_ready_i;
  assign emit_ok  = (tot_q >= LenW'(8)) && can_out;
  assign tot_cur  = emit_ok ? (tot_q - LenW'(8)) : tot_q;
  assign sh       = tot_q - LenW'(8);
  assign shifted  = acc_q >> sh;
  assign cnt      = tot_cur[2:0];
  assign pend     = acc_q[6:0] & ~(7'h7F << cnt);
  assign code_m   = q_ent_i.code & ~({CodeW{1'b1}} << q_ent_i.len);
  assign acc_new  = ({{(AccW-7){1'b0}}, pend} << q_ent_i.len) |
                    {{(AccW-CodeW){1'b0}}, code_m};

  // an encode may enter as soon as the residue drops below a byte
  assign pop_enc  = q_valid_i && (q_ent_i.kind == KIND_ENC) && (tot_cur < LenW'(8));
  assign pop_side = q_valid_i && (q_ent_i.kind != KIND_ENC) &&
                    (tot_q < LenW'(8)) && can_out;
  assign q_pop_o  = pop_enc || pop_side;

  assign pad      = 3'd0 - cnt;
  assign fin_byte = 8'({1'b0, pend} << pad);

  always_comb begin
    acc_d = acc_q;
    tot_d = tot_cur;
    if (pop_enc) begin
      acc_d = acc_new;
      tot_d = {3'd0, cnt} + q_ent_i.len;
    end else if (pop_side && (q_ent_i.kind == KIND_FIN)) begin
      tot_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      tot_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      tot_q <= tot_d;
      if (emit_ok || pop_side) begin
        ovld_q <= 1'b1;
      end else if (out_ready_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ok) begin
      ores_q.out_byte       <= shifted[7:0];
      ores_q.byte_valid     <= 1'b1;
      ores_q.padding_bits   <= '0;
      ores_q.stream_end     <= 1'b0;
      ores_q.missing_symbol <= 1'b0;
      ores_q.last           <= (tot_q < LenW'(16));
    end else if (pop_side) begin
      if (q_ent_i.kind == KIND_FIN) begin
        ores_q.out_byte       <= (cnt != 3'd0) ? fin_byte : 8'd0;
        ores_q.byte_valid     <= (cnt != 3'd0);
        ores_q.padding_bits   <= pad;
        ores_q.stream_end     <= 1'b1;
        ores_q.missing_symbol <= 1'b0;
      end else begin
        ores_q.out_byte       <= '0;
        ores_q.byte_valid     <= 1'b0;
        ores_q.padding_bits   <= '0;
        ores_q.stream_end     <= 1'b0;
        ores_q.missing_symbol <= 1'b1;
      end
      ores_q.last <= 1'b1;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_res_o   = ores_q;

endmodule

// ===== rtl/prefix_code_bit_packer.sv =====
// ----------------------------------------------------------------------------
// prefix_code_bit_packer
// Huffman encoder back end: code table, symbol lookup and byte packing.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the queue has room. Loads write the 256-entry
// code table and give no word; the table marks are cleared by reset at once,
// so no clearing pass is needed. Encode and finish items go through a
// registered table lookup, then a 4-entry queue, then the packer, which emits
// one output word per cycle unless the output stalls: an encode that completes
// n bytes gives n words (up to 4 for a 32-bit code), while encodes that complete
// at most one byte, misses and finishes each sustain one item per cycle; a miss
// or finish right behind an encode that completed a byte waits until that byte
// is emitted. Results pass the lookup register, the queue and the output
// register, an encode's bytes also the residue register; the queue lets the
// input keep flowing while the output is stalled or a long code is being unpacked.
module prefix_code_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] action, [9:2] symbol, [41:10] code_value, [47:42] code_length
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] out_byte, [8] byte_valid, [11:9] padding_bits, [12] stream_end,
  // [13] missing_symbol, [15:14] zero
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);
  import pcbp_pkg::*;

  logic  push_valid, push_ready;
  qent_t push_ent;
  logic  q_valid, q_pop;
  qent_t q_ent;
  res_t  res;

  pcbp_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .action_i     (s_axis_tdata_i[1:0]),
    .symbol_i     (s_axis_tdata_i[9:2]),
    .code_value_i (s_axis_tdata_i[41:10]),
    .code_length_i(s_axis_tdata_i[47:42]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_ent_o   (push_ent)
  );

  pcbp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_ent_i  (push_ent),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_ent_o   (q_ent)
  );

  pcbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ent_i    (q_ent),
    .q_pop_o    (q_pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_res_o  (res)
  );

  assign m_axis_tdata_o = {2'b00, res.missing_symbol, res.stream_end,
                           res.padding_bits, res.byte_valid, res.out_byte};
  assign m_axis_tlast_o = res.last;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for prefix_code_bit_packer. A bit-accurate model of
// the code table and the bit stream predicts every output word. Stimulus is
// a directed pass over the edge cases, then random code tables and symbol
// streams with finishes. Both stream sides idle in random bursts, except in the final run.
// ----------------------------------------------------------------------------
module tb;
  import pcbp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxCodeLen = 32;
  localparam int unsigned LenCap     = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;
  localparam logic [1:0]  ActUnused  = 2'd3;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 20;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  // model state
  logic [CodeW-1:0] code_tab [NumSyms];
  logic [LenW-1:0]  len_tab  [NumSyms];
  bit               mark_tab [NumSyms];
  logic [6:0]       pend_bits = '0;
  logic [2:0]       pend_cnt  = '0;

  res_t        exp_words [$];
  logic [7:0]  loaded_syms [$];
  bit          idle_en  = 1'b1;
  int unsigned err_cnt  = 0;
  int unsigned cyc_cnt  = 0;

  prefix_code_bit_packer #(
    .MAX_CODE_LEN(MaxCodeLen)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CycleLimit) begin
      $display("%0t: timeout, %0d words still expected", $time, exp_words.size());
      $display("prefix_code_bit_packer: mismatch");
      $finish;
    end
  end

  function automatic logic [38:0] low_bits(input int unsigned n);
    return (39'd1 << n) - 39'd1;
  endfunction

  // Update the model for one accepted item and queue the words it yields.
  task automatic predict_words(input logic [1:0] act, input logic [7:0] sym,
                               input logic [31:0] cval, input logic [5:0] clen);
    logic [38:0] acc;
    int unsigned len;
    int unsigned total;
    int unsigned n;
    res_t r;
    r = '0;
    n = 0;
    case (act)
      ACT_LOAD: begin
        code_tab[sym] = cval;
        len_tab[sym]  = (clen > LenCap) ? LenW'(LenCap) : clen;
        mark_tab[sym] = 1'b1;
      end
      ACT_ENCODE: begin
        if (!mark_tab[sym]) begin
          r.missing_symbol = 1'b1;
          r.last           = 1'b1;
          exp_words.push_back(r);
        end else begin
          len   = len_tab[sym];
          acc   = (39'(pend_bits) << len) | (39'(code_tab[sym]) & low_bits(len));
          total = pend_cnt + len;
          while (total >= 8) begin
            total -= 8;
            r.out_byte   = 8'(acc >> total);
            r.byte_valid = 1'b1;
            exp_words.push_back(r);
            n++;
          end
          pend_bits = 7'(acc & low_bits(total));
          pend_cnt  = 3'(total);
          if (n > 0) exp_words[$].last = 1'b1;
        end
      end
      ACT_FINISH: begin
        r.stream_end = 1'b1;
        r.last       = 1'b1;
        if (pend_cnt != 0) begin
          r.padding_bits = 3'(8 - pend_cnt);
          r.out_byte     = 8'(pend_bits << (8 - pend_cnt));
          r.byte_valid   = 1'b1;
        end
        exp_words.push_back(r);
        pend_bits = '0;
        pend_cnt  = '0;
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [1:0] act, input logic [7:0] sym,
                           input logic [31:0] cval, input logic [5:0] clen);
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {clen, cval, sym, act};
    do @(posedge clk); while (!s_tready);
    predict_words(act, sym, cval, clen);
  endtask

  task automatic send_load(input logic [7:0] sym, input logic [31:0] cval,
                           input logic [5:0] clen);
    loaded_syms.push_back(sym);
    send_word(ACT_LOAD, sym, cval, clen);
  endtask

  task automatic release_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (exp_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [5:0] rand_length();
    if ($urandom_range(0, 7) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(1, 12));
  endfunction

  function automatic string fmt_word(input res_t r);
    return $sformatf("byte=%h bv=%b pad=%0d end=%b miss=%b last=%b", r.out_byte,
                     r.byte_valid, r.padding_bits, r.stream_end, r.missing_symbol,
                     r.last);
  endfunction

  // output side: random stall bursts while idling is enabled
  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
        @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && m_tvalid && m_tready) begin
      got.out_byte       = m_tdata[7:0];
      got.byte_valid     = m_tdata[8];
      got.padding_bits   = m_tdata[11:9];
      got.stream_end     = m_tdata[12];
      got.missing_symbol = m_tdata[13];
      got.last           = m_tlast;
      if (exp_words.size() == 0) begin
        $display("%0t: unexpected word, got %s", $time, fmt_word(got));
        err_cnt++;
      end else begin
        want = exp_words.pop_front();
        if (got !== want || m_tdata[15:14] !== 2'b00) begin
          $display("%0t: word mismatch\n  expected %s\n  actual   %s (tdata=%h)",
                   $time, fmt_word(want), fmt_word(got), m_tdata);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_missing_symbol();
    send_word(ACT_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'h3F);
    send_word(ACT_ENCODE, 8'hFF, 32'h0000_0000, 6'h00);
  endtask

  task automatic test_finish_empty();
    send_word(ACT_FINISH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
  endtask

  task automatic test_zero_length();
    send_load(8'h10, 32'hDEAD_BEEF, 6'd0);
    send_word(ACT_ENCODE, 8'h10, 32'h0, 6'd0);
    send_word(ACT_FINISH, 8'h00, 32'h0, 6'd0);
  endtask

  // lengths above 32 saturate; 32-bit codes give up to four bytes
  task automatic test_long_codes();
    send_load(8'hFF, 32'hFFFF_FFFF, 6'd63);
    send_load(8'h00, 32'h0000_0000, 6'd32);
    send_load(8'hA5, 32'h8000_0001, 6'd33);
    send_word(ACT_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_word(ACT_ENCODE, 8'h00, 32'h0, 6'd0);
    send_word(ACT_ENCODE, 8'hA5, 32'h0, 6'd0);
    send_load(8'h01, 32'hFFFF_FFFD, 6'd3);
    send_load(8'h02, 32'h5555_5555, 6'd7);
    send_word(ACT_ENCODE, 8'h01, 32'h0, 6'd0);
    send_word(ACT_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_word(ACT_ENCODE, 8'h02, 32'h0, 6'd0);
    send_word(ACT_ENCODE, 8'hA5, 32'h0, 6'd0);
    send_word(ACT_FINISH, 8'h00, 32'h0, 6'd0);
    send_word(ACT_ENCODE, 8'h01, 32'h0, 6'd0);
    send_word(ACT_FINISH, 8'h00, 32'h0, 6'd0);
  endtask

  task automatic test_unknown_action();
    send_word(ActUnused, 8'h00, 32'hFFFF_FFFF, 6'h3F);
    send_word(ActUnused, 8'h33, 32'h0000_0000, 6'h00);
    send_word(ACT_ENCODE, 8'h33, 32'h0, 6'd0);
    send_word(ACT_ENCODE, 8'h02, 32'h0, 6'd0);
    send_word(ACT_FINISH, 8'h00, 32'h0, 6'd0);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [7:0] sym;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_load(8'($urandom_range(0, 255)), $urandom(), rand_length());
    end else if (pick < 75) begin
      if ($urandom_range(0, 9) != 0)
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
      else
        sym = 8'($urandom_range(0, 255));
      send_word(ACT_ENCODE, sym, $urandom(), 6'($urandom_range(0, 63)));
    end else if (pick < 90) begin
      send_word(ACT_FINISH, 8'($urandom_range(0, 255)), $urandom(),
                6'($urandom_range(0, 63)));
    end else if (pick < 95) begin
      send_word(ActUnused, 8'($urandom_range(0, 255)), $urandom(),
                6'($urandom_range(0, 63)));
    end else begin
      send_load(8'($urandom_range(0, 255)), $urandom(), 6'($urandom_range(28, 63)));
    end
  endtask

  // fresh codes for a batch of symbols, then a mostly well-formed stream
  task automatic test_random_stream(input int unsigned n_items);
    repeat (16) send_load(8'($urandom_range(0, 255)), $urandom(), rand_length());
    repeat (n_items) send_random_item();
    send_word(ACT_FINISH, 8'($urandom_range(0, 255)), $urandom(), rand_length());
  endtask

  task automatic test_no_idle(input int unsigned n_items);
    wait_drained();
    idle_en = 1'b0;
    repeat (n_items) send_random_item();
    send_word(ACT_FINISH, 8'h00, 32'h0, 6'd0);
  endtask

  initial begin
    foreach (mark_tab[i]) mark_tab[i] = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_missing_symbol();
    test_finish_empty();
    test_zero_length();
    test_long_codes();
    test_unknown_action();
    test_random_stream(160);
    wait_drained();
    test_random_stream(140);
    test_no_idle(80);

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (err_cnt == 0 && exp_words.size() == 0) begin
      $display("prefix_code_bit_packer: match");
    end else begin
      $display("prefix_code_bit_packer: mismatch");
    end
    $finish;
  end

endmodule
